// ===== src/bmp_pixel_row_unpacker_macros.svh =====
// assertion macros for the bmp pixel row unpacker
`ifndef BMP_PIXEL_ROW_UNPACKER_MACROS_SVH
`define BMP_PIXEL_ROW_UNPACKER_MACROS_SVH

`ifndef SYNTHESIS
// property must hold at every clock edge out of reset
`define BPRU_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("bmp pixel row unpacker check failed");
// condition must never be seen out of reset
`define BPRU_ASSERT_NEVER(label, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("bmp pixel row unpacker forbidden condition");
`else
`define BPRU_ASSERT(label, prop)
`define BPRU_ASSERT_NEVER(label, cond)
`endif

`endif

// ===== src/bmpu_pkg.sv =====
// shared types, constants and helpers of the bmp pixel row unpacker
package bmpu_pkg;

  localparam int unsigned MaxDim    = 4096;
  localparam int unsigned DimW      = 13;
  localparam int unsigned CoordW    = 12;
  localparam int unsigned ByteW     = 8;
  localparam int unsigned RgbW      = 24;
  localparam int unsigned WordW     = 32;
  localparam int unsigned CfgIndexW = 2;
  localparam int unsigned CfgDataW  = 24;

  // configuration register indexes
  localparam logic [CfgIndexW-1:0] RegImageWidth  = 2'd0;
  localparam logic [CfgIndexW-1:0] RegImageHeight = 2'd1;
  localparam logic [CfgIndexW-1:0] RegPixelSize   = 2'd2;
  localparam logic [CfgIndexW-1:0] RegKeyColor    = 2'd3;

  // pixel size modes
  localparam logic ModeBpp24 = 1'b0;
  localparam logic ModeBpp32 = 1'b1;

  // byte positions within a pixel
  localparam logic [1:0] PhaseBlue  = 2'd0;
  localparam logic [1:0] PhaseGreen = 2'd1;
  localparam logic [1:0] PhaseRed   = 2'd2;
  localparam logic [1:0] PhaseAlpha = 2'd3;

  localparam logic [ByteW-1:0] AlphaOpaque = 8'hFF;
  localparam logic [ByteW-1:0] MaskClear   = 8'h00;
  localparam logic [DimW-1:0]  DimMax      = DimW'(MaxDim);
  localparam logic [RgbW-1:0]  KeyReset    = 24'hFF00FF;

  typedef struct packed {
    logic [DimW-1:0] image_width;
    logic [DimW-1:0] image_height;
    logic            pixel_size_mode;
    logic [RgbW-1:0] key_color;
  } cfg_t;

  typedef struct packed {
    logic [WordW-1:0]  pixel_word;
    logic [ByteW-1:0]  mask_value;
    logic [CoordW-1:0] column;
    logic [CoordW-1:0] row;
    logic              last_pixel;
  } result_t;

  // status of the gathering logic, for checks at the top level
  typedef struct packed {
    logic image_done;
    logic res_valid;
  } core_status_t;

  // zero reads as one, anything above the maximum as the maximum
  function automatic logic [DimW-1:0] clamp_dim(input logic [DimW-1:0] v);
    logic [DimW-1:0] r;
    if (v == '0) begin
      r = DimW'(1);
    end else if (v > DimMax) begin
      r = DimMax;
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

// ===== src/bmpu_core.sv =====
// byte gathering, row/column counting and pixel result forming
module bmpu_core (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                accept,
  input  logic [bmpu_pkg::ByteW-1:0]          data_byte,
  input  logic                                frame_start,
  input  bmpu_pkg::cfg_t                      cfg,
  output bmpu_pkg::result_t                   res,
  output bmpu_pkg::core_status_t              status
);

  logic [1:0]                    phase_r, phase_nxt;
  logic [bmpu_pkg::RgbW-1:0]     hold_r, hold_nxt;
  logic [bmpu_pkg::CoordW-1:0]   col_r, col_nxt;
  logic [bmpu_pkg::CoordW-1:0]   rowc_r, rowc_nxt;
  logic [1:0]                    pad_r, pad_nxt;
  logic                          done_r, done_nxt;

  logic [1:0]                    phase_e;
  logic [bmpu_pkg::RgbW-1:0]     hold_e;
  logic [bmpu_pkg::CoordW-1:0]   col_e, rowc_e;
  logic [1:0]                    pad_e;
  logic                          done_e;
  logic [bmpu_pkg::DimW-1:0]     w, h;
  logic [1:0]                    last_phase;
  logic [bmpu_pkg::RgbW-1:0]     rgb;
  logic [bmpu_pkg::DimW-1:0]     row_full;
  logic                          row_end, img_end;
  logic                          res_valid;

  assign w = bmpu_pkg::clamp_dim(cfg.image_width);
  assign h = bmpu_pkg::clamp_dim(cfg.image_height);
  assign last_phase = (cfg.pixel_size_mode == bmpu_pkg::ModeBpp32) ?
                      bmpu_pkg::PhaseAlpha : bmpu_pkg::PhaseRed;

  // frame start clears the state before the byte is used
  always_comb begin
    if (frame_start) begin
      phase_e = '0;
      hold_e  = '0;
      col_e   = '0;
      rowc_e  = '0;
      pad_e   = '0;
      done_e  = 1'b0;
    end else begin
      phase_e = phase_r;
      hold_e  = hold_r;
      col_e   = col_r;
      rowc_e  = rowc_r;
      pad_e   = pad_r;
      done_e  = done_r;
    end
  end

  // pixel fields from the held bytes and the completing byte
  always_comb begin
    if (cfg.pixel_size_mode == bmpu_pkg::ModeBpp32) begin
      rgb = hold_e;
    end else begin
      rgb = {data_byte, hold_e[15:0]};
    end
    row_full = h - bmpu_pkg::DimW'(1) - {1'b0, rowc_e};
    row_end  = ({1'b0, col_e} + bmpu_pkg::DimW'(1)) >= w;
    img_end  = row_end && (({1'b0, rowc_e} + bmpu_pkg::DimW'(1)) >= h);

    res.pixel_word = {bmpu_pkg::AlphaOpaque, rgb};
    if (cfg.pixel_size_mode == bmpu_pkg::ModeBpp32) begin
      res.mask_value = data_byte;
    end else if (rgb == cfg.key_color) begin
      res.mask_value = bmpu_pkg::MaskClear;
    end else begin
      res.mask_value = bmpu_pkg::AlphaOpaque;
    end
    res.column     = col_e;
    res.row        = row_full[bmpu_pkg::CoordW-1:0];
    res.last_pixel = img_end;
  end

  // next state for one request
  always_comb begin
    phase_nxt = phase_e;
    hold_nxt  = hold_e;
    col_nxt   = col_e;
    rowc_nxt  = rowc_e;
    pad_nxt   = pad_e;
    done_nxt  = done_e;
    res_valid = 1'b0;
    if (done_e) begin
      // image complete, byte ignored
    end else if (pad_e != 2'd0) begin
      pad_nxt = pad_e - 2'd1;
    end else if (phase_e < last_phase) begin
      case (phase_e)
        bmpu_pkg::PhaseBlue:  hold_nxt = hold_e | {16'd0, data_byte};
        bmpu_pkg::PhaseGreen: hold_nxt = hold_e | {8'd0, data_byte, 8'd0};
        bmpu_pkg::PhaseRed:   hold_nxt = hold_e | {data_byte, 16'd0};
        default:              hold_nxt = hold_e;
      endcase
      phase_nxt = phase_e + 2'd1;
    end else begin
      res_valid = 1'b1;
      phase_nxt = '0;
      hold_nxt  = '0;
      if (img_end) begin
        done_nxt = 1'b1;
      end else if (row_end) begin
        col_nxt  = '0;
        rowc_nxt = rowc_e + bmpu_pkg::CoordW'(1);
        // padding to a multiple of four bytes equals width mod 4 at 24 bpp
        pad_nxt  = (cfg.pixel_size_mode == bmpu_pkg::ModeBpp32) ? 2'd0 : w[1:0];
      end else begin
        col_nxt = col_e + bmpu_pkg::CoordW'(1);
      end
    end
  end

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= '0;
      hold_r  <= '0;
      col_r   <= '0;
      rowc_r  <= '0;
      pad_r   <= '0;
      done_r  <= 1'b0;
    end else if (accept) begin
      phase_r <= phase_nxt;
      hold_r  <= hold_nxt;
      col_r   <= col_nxt;
      rowc_r  <= rowc_nxt;
      pad_r   <= pad_nxt;
      done_r  <= done_nxt;
    end
  end

  assign status.image_done = done_e;
  assign status.res_valid  = res_valid;

endmodule

// ===== src/bmp_pixel_row_unpacker.sv =====
// top level of the bmp pixel row unpacker
//
// Takes the pixel-data area of a 24 or 32 bpp bitmap one byte per request
// on the in_ channel (in_frame_start high on the first byte of an image)
// and returns one request per completed pixel on the out_ channel: ARGB
// word with opaque alpha, mask byte, column and display row (rows flipped
// to top-down), with out_last_pixel on the final pixel. Row padding bytes
// and bytes after the last pixel produce nothing.
// Throughput is one byte per cycle while in_stall is low; the gathering logic sits
// between the input byte and the result register, so a pixel is registered into
// the result register, or into the skid register while out_ stalls, as its last byte is taken.
// The result register is backed by a one-entry skid register: while the
// receiver stalls, one more pixel can be absorbed, after which in_stall
// rises until the skid register drains.
// Configuration is written on the cfg_ channel (always ready); the user must write it
// only while idle, which the block itself does not enforce. Synchronous reset loads
// the register defaults (1x1 image, 24 bpp, key colour magenta), clears all counters and empties the output stages.
`include "bmp_pixel_row_unpacker_macros.svh"

module bmp_pixel_row_unpacker (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // input byte channel
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic [bmpu_pkg::ByteW-1:0]           in_data_byte,
  input  logic                                 in_frame_start,
  // pixel result channel
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic [bmpu_pkg::WordW-1:0]           out_pixel_word,
  output logic [bmpu_pkg::ByteW-1:0]           out_mask_value,
  output logic [bmpu_pkg::CoordW-1:0]          out_column,
  output logic [bmpu_pkg::CoordW-1:0]          out_row,
  output logic                                 out_last_pixel,
  // configuration write channel
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [bmpu_pkg::CfgIndexW-1:0]       cfg_index,
  input  logic [bmpu_pkg::CfgDataW-1:0]        cfg_data
);

  bmpu_pkg::cfg_t          cfg_r;
  bmpu_pkg::result_t       core_res;
  bmpu_pkg::core_status_t  core_status;
  bmpu_pkg::result_t       out_r, skid_r;
  logic                    out_valid_r, skid_valid_r;
  logic                    in_acc, out_take, new_res;

  assign cfg_ready = 1'b1;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.image_width     <= bmpu_pkg::DimW'(1);
      cfg_r.image_height    <= bmpu_pkg::DimW'(1);
      cfg_r.pixel_size_mode <= bmpu_pkg::ModeBpp24;
      cfg_r.key_color       <= bmpu_pkg::KeyReset;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        bmpu_pkg::RegImageWidth:  cfg_r.image_width     <= cfg_data[bmpu_pkg::DimW-1:0];
        bmpu_pkg::RegImageHeight: cfg_r.image_height    <= cfg_data[bmpu_pkg::DimW-1:0];
        bmpu_pkg::RegPixelSize:   cfg_r.pixel_size_mode <= cfg_data[0];
        bmpu_pkg::RegKeyColor:    cfg_r.key_color       <= cfg_data[bmpu_pkg::RgbW-1:0];
        default: ;
      endcase
    end
  end

  assign in_stall = skid_valid_r;
  assign in_acc   = in_valid && !in_stall;
  assign out_take = out_valid_r && !out_stall;
  assign new_res  = in_acc && core_status.res_valid;

  bmpu_core u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .accept      (in_acc),
    .data_byte   (in_data_byte),
    .frame_start (in_frame_start),
    .cfg         (cfg_r),
    .res         (core_res),
    .status      (core_status)
  );

  // output register and skid register control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (!out_valid_r || out_take) begin
      if (skid_valid_r) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end else begin
        out_valid_r <= new_res;
      end
    end else if (new_res) begin
      skid_valid_r <= 1'b1;
    end
  end

  // output and skid payload
  always_ff @(posedge clk) begin
    if (!out_valid_r || out_take) begin
      if (skid_valid_r) begin
        out_r <= skid_r;
      end else if (new_res) begin
        out_r <= core_res;
      end
    end else if (new_res) begin
      skid_r <= core_res;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_pixel_word = out_r.pixel_word;
  assign out_mask_value = out_r.mask_value;
  assign out_column     = out_r.column;
  assign out_row        = out_r.row;
  assign out_last_pixel = out_r.last_pixel;

  // checks
  `BPRU_ASSERT(a_skid_needs_out, skid_valid_r |-> out_valid_r)
  `BPRU_ASSERT_NEVER(a_res_after_done, core_status.res_valid && core_status.image_done)
  `BPRU_ASSERT(a_skid_fills,
      (new_res && out_valid_r && out_stall && !skid_valid_r) |=> skid_valid_r)
  `BPRU_ASSERT(a_skid_drains, (skid_valid_r && !out_stall) |=> !skid_valid_r)

endmodule

// ===== tb/sv/tb_top.sv =====
// testbench of the bmp pixel row unpacker: byte streams checked pixel by pixel against a predictor
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import bmpu_pkg::*;

  localparam int unsigned StuckLimit   = 4000;
  localparam int unsigned SettleCycles = 8;
  localparam int unsigned HoldCycles   = 150;
  localparam int unsigned ItemTarget   = 1300;
  localparam int unsigned TailItems    = 60;
  localparam int unsigned FrameCap     = 80;
  localparam int unsigned DimAllOnes   = (1 << DimW) - 1;
  localparam logic [ByteW-1:0] MaskOpaque = 8'hFF;

  typedef struct {
    logic [ByteW-1:0] data;
    logic             frame_start;
  } byte_req_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [ByteW-1:0]     in_data_byte = '0;
  logic                 in_frame_start = 1'b0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [WordW-1:0]     out_pixel_word;
  logic [ByteW-1:0]     out_mask_value;
  logic [CoordW-1:0]    out_column;
  logic [CoordW-1:0]    out_row;
  logic                 out_last_pixel;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CfgIndexW-1:0] cfg_index = '0;
  logic [CfgDataW-1:0]  cfg_data = '0;

  // predictor copy of the registers and the gathering state
  logic [DimW-1:0]   pred_width = DimW'(1);
  logic [DimW-1:0]   pred_height = DimW'(1);
  logic              pred_mode = ModeBpp24;
  logic [RgbW-1:0]   pred_key = KeyReset;
  logic [1:0]        gather_phase = PhaseBlue;
  logic [RgbW-1:0]   gather_rgb = '0;
  logic [CoordW-1:0] file_col = '0;
  logic [CoordW-1:0] file_row = '0;
  logic [1:0]        pad_bytes = '0;
  bit                image_complete = 1'b0;

  result_t     pending_pixels[$];
  byte_req_t   byte_stream[$];
  int unsigned items_sent = 0;
  int unsigned mismatches = 0;
  int unsigned send_gap = 0;
  int unsigned send_pct = 0;
  int unsigned stall_pct = 0;
  int unsigned stall_left = 0;
  int unsigned hold_left = 0;
  int unsigned hold_asks = 0;
  int unsigned hold_done = 0;
  int unsigned stuck_cycles = 0;
  bit          calm_tail = 1'b0;

  bmp_pixel_row_unpacker u_top (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_data_byte   (in_data_byte),
    .in_frame_start (in_frame_start),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_pixel_word (out_pixel_word),
    .out_mask_value (out_mask_value),
    .out_column     (out_column),
    .out_row        (out_row),
    .out_last_pixel (out_last_pixel),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  // 4 ns clock
  initial begin
    forever #2 clk = ~clk;
  end

  // zero reads as one, oversize as the maximum
  function automatic int unsigned eff_dim(input logic [DimW-1:0] v);
    int unsigned d;
    d = 32'(v);
    if (d == 0) begin
      d = 1;
    end else if (d > MaxDim) begin
      d = MaxDim;
    end
    return d;
  endfunction

  function automatic void apply_reg(input logic [CfgIndexW-1:0] idx,
                                    input logic [CfgDataW-1:0] val);
    case (idx)
      RegImageWidth:  pred_width = val[DimW-1:0];
      RegImageHeight: pred_height = val[DimW-1:0];
      RegPixelSize:   pred_mode = val[0];
      RegKeyColor:    pred_key = val[RgbW-1:0];
      default: ;
    endcase
  endfunction

  // one accepted byte: gather, skip padding, or complete a pixel
  function automatic void unpack_byte(input logic [ByteW-1:0] b, input logic fs);
    int unsigned     w;
    int unsigned     h;
    logic [1:0]      final_phase;
    logic [RgbW-1:0] rgb;
    result_t         px;
    bit              row_end;
    bit              img_end;
    w = eff_dim(pred_width);
    h = eff_dim(pred_height);
    final_phase = (pred_mode == ModeBpp32) ? PhaseAlpha : PhaseRed;
    if (fs) begin
      gather_phase = PhaseBlue;
      gather_rgb = '0;
      file_col = '0;
      file_row = '0;
      pad_bytes = '0;
      image_complete = 1'b0;
    end
    if (image_complete) begin
      return;
    end
    if (pad_bytes != 0) begin
      pad_bytes = pad_bytes - 2'd1;
      return;
    end
    if (gather_phase < final_phase) begin
      gather_rgb = gather_rgb | (RgbW'(b) << (8 * gather_phase));
      gather_phase = gather_phase + 2'd1;
      return;
    end
    // pixel complete; in 24 bpp any late byte position acts as red
    if (pred_mode == ModeBpp32) begin
      rgb = gather_rgb;
      px.mask_value = b;
    end else begin
      rgb = {b, gather_rgb[15:0]};
      px.mask_value = (rgb == pred_key) ? MaskClear : MaskOpaque;
    end
    row_end = (32'(file_col) + 1 >= w);
    img_end = row_end && (32'(file_row) + 1 >= h);
    px.pixel_word = {AlphaOpaque, rgb};
    px.column = file_col;
    px.row = CoordW'(h - 1 - 32'(file_row));
    px.last_pixel = img_end;
    pending_pixels.push_back(px);
    gather_phase = PhaseBlue;
    gather_rgb = '0;
    if (img_end) begin
      image_complete = 1'b1;
    end else if (row_end) begin
      file_col = '0;
      file_row = file_row + 1'b1;
      pad_bytes = (pred_mode == ModeBpp32) ? 2'd0 : 2'((4 - (w * 3) % 4) % 4);
    end else begin
      file_col = file_col + 1'b1;
    end
  endfunction

  function automatic void note_mismatch(input string msg);
    mismatches++;
    if (mismatches <= 10) begin
      $display("mismatch at %0t:%s", $realtime, msg);
    end
  endfunction

  // compare one accepted pixel with the oldest expectation
  function automatic void check_pixel();
    result_t want;
    string   diff;
    if (pending_pixels.size() == 0) begin
      note_mismatch($sformatf(" unexpected pixel word %h mask %h col %0d row %0d last %b",
                              out_pixel_word, out_mask_value, out_column, out_row,
                              out_last_pixel));
      return;
    end
    want = pending_pixels.pop_front();
    diff = "";
    if (out_pixel_word !== want.pixel_word) begin
      diff = {diff, $sformatf(" pixel_word exp %h got %h", want.pixel_word, out_pixel_word)};
    end
    if (out_mask_value !== want.mask_value) begin
      diff = {diff, $sformatf(" mask exp %h got %h", want.mask_value, out_mask_value)};
    end
    if (out_column !== want.column) begin
      diff = {diff, $sformatf(" column exp %0d got %0d", want.column, out_column)};
    end
    if (out_row !== want.row) begin
      diff = {diff, $sformatf(" row exp %0d got %0d", want.row, out_row)};
    end
    if (out_last_pixel !== want.last_pixel) begin
      diff = {diff, $sformatf(" last exp %b got %b", want.last_pixel, out_last_pixel)};
    end
    if (diff != "") begin
      note_mismatch(diff);
    end
  endfunction

  // byte driver: one request per free slot, random gaps after acceptance
  always @(posedge clk) begin : drive_bytes
    byte_req_t req;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        unpack_byte(in_data_byte, in_frame_start);
        if (!calm_tail && send_pct != 0 && $urandom_range(99) < send_pct) begin
          send_gap = $urandom_range(19, 1);
        end
      end
      if (!in_valid || !in_stall) begin
        if (send_gap != 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (byte_stream.size() != 0) begin
          req = byte_stream.pop_front();
          in_valid <= 1'b1;
          in_data_byte <= req.data;
          in_frame_start <= req.frame_start;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // pixel monitor and receiver stall pattern
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        check_pixel();
      end
      if (hold_left != 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (hold_done != hold_asks) begin
        hold_done++;
        hold_left = HoldCycles - 1;
        out_stall <= 1'b1;
      end else if (stall_left != 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else if (!calm_tail && stall_pct != 0 && $urandom_range(99) < stall_pct) begin
        stall_left = $urandom_range(19, 1) - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // register tracking and watchdog on lack of progress
  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_valid && cfg_ready) begin
        apply_reg(cfg_index, cfg_data);
      end
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
        stuck_cycles = 0;
      end else begin
        stuck_cycles++;
        if (stuck_cycles >= StuckLimit) begin
          $display("bmp_pixel_row_unpacker regression: fail");
          $finish;
        end
      end
    end
  end

  task automatic write_reg(input logic [CfgIndexW-1:0] idx, input int unsigned val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= CfgDataW'(val);
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  // wait until every byte is taken and every pixel has come out
  task automatic drain();
    @(negedge clk);
    while (byte_stream.size() != 0 || in_valid || pending_pixels.size() != 0) begin
      @(negedge clk);
    end
  endtask

  // drained, plus time for a byte that gives no pixel to settle
  task automatic settle();
    drain();
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic configure(input int unsigned w, input int unsigned h, input logic mode,
                           input logic [RgbW-1:0] key);
    settle();
    write_reg(RegImageWidth, w);
    write_reg(RegImageHeight, h);
    write_reg(RegPixelSize, 32'(mode));
    write_reg(RegKeyColor, 32'(key));
    @(negedge clk);
  endtask

  function automatic void queue_byte(input logic [ByteW-1:0] b, input logic fs,
                                     input bit counts);
    byte_req_t req;
    req.data = b;
    req.frame_start = fs;
    byte_stream.push_back(req);
    if (counts) begin
      items_sent++;
    end
  endfunction

  // bytes leaning towards all zeros and all ones
  function automatic logic [ByteW-1:0] rand_byte();
    logic [ByteW-1:0] b;
    case ($urandom_range(7))
      0:       b = 8'h00;
      1:       b = 8'hFF;
      default: b = ByteW'($urandom);
    endcase
    return b;
  endfunction

  function automatic int unsigned pick_dim();
    int unsigned d;
    case ($urandom_range(15))
      0:       d = 0;
      1:       d = MaxDim;
      2:       d = DimAllOnes;
      3:       d = $urandom_range(DimAllOnes);
      default: d = $urandom_range(6, 1);
    endcase
    return d;
  endfunction

  function automatic logic [RgbW-1:0] pick_key();
    logic [RgbW-1:0] k;
    case ($urandom_range(3))
      0:       k = '0;
      1:       k = '1;
      default: k = RgbW'($urandom);
    endcase
    return k;
  endfunction

  function automatic int unsigned pick_pct();
    int unsigned p;
    case ($urandom_range(4))
      0, 1:    p = 0;
      2:       p = 5;
      3:       p = 15;
      default: p = 40;
    endcase
    return p;
  endfunction

  // well-formed image for the current settings, cut short after about cap bytes
  function automatic void queue_image(input int unsigned cap);
    int unsigned     w;
    int unsigned     h;
    int unsigned     pad;
    int unsigned     sent;
    logic [RgbW-1:0] rgb;
    bit              first;
    w = eff_dim(pred_width);
    h = eff_dim(pred_height);
    pad = (pred_mode == ModeBpp32) ? 0 : (4 - (w * 3) % 4) % 4;
    sent = 0;
    first = 1'b1;
    for (int unsigned r = 0; r < h && sent < cap; r++) begin
      for (int unsigned c = 0; c < w && sent < cap; c++) begin
        if (pred_mode == ModeBpp24 && $urandom_range(3) == 0) begin
          rgb = pred_key;
        end else begin
          rgb = {rand_byte(), rand_byte(), rand_byte()};
        end
        queue_byte(rgb[7:0], first, 1'b1);
        queue_byte(rgb[15:8], 1'b0, 1'b1);
        queue_byte(rgb[23:16], 1'b0, 1'b1);
        sent += 3;
        if (pred_mode == ModeBpp32) begin
          queue_byte(rand_byte(), 1'b0, 1'b1);
          sent++;
        end
        first = 1'b0;
      end
      if (r + 1 < h) begin
        for (int unsigned p = 0; p < pad; p++) begin
          queue_byte(rand_byte(), 1'b0, 1'b1);
          sent++;
        end
      end
    end
    // stray bytes after a finished image
    if (sent < cap && $urandom_range(3) == 0) begin
      repeat ($urandom_range(3, 1)) queue_byte(rand_byte(), 1'b0, 1'b0);
    end
  endfunction

  function automatic void queue_noise(input int unsigned n);
    repeat (n) queue_byte(rand_byte(), ($urandom_range(9) == 0), 1'b1);
  endfunction

  task automatic random_phase();
    configure(pick_dim(), pick_dim(), 1'($urandom_range(1)), pick_key());
    send_pct = pick_pct();
    stall_pct = pick_pct();
    repeat ($urandom_range(4, 1)) begin
      case ($urandom_range(9))
        0: queue_noise($urandom_range(12, 1));
        1: queue_image($urandom_range(10, 1));
        2: begin
          // sender pause until every pixel is out
          drain();
          queue_image(FrameCap);
        end
        default: queue_image(FrameCap);
      endcase
    end
  endtask

  // stimulus
  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // reset settings without a frame start: 1x1 magenta is keyed, then a byte past the end
    queue_byte(8'hFF, 1'b0, 1'b1);
    queue_byte(8'h00, 1'b0, 1'b1);
    queue_byte(8'hFF, 1'b0, 1'b1);
    queue_byte(8'h12, 1'b0, 1'b0);
    // frame start restarts the image
    queue_byte(8'h00, 1'b1, 1'b1);
    queue_byte(8'h00, 1'b0, 1'b1);
    queue_byte(8'h00, 1'b0, 1'b1);

    // width zero reads as one, oversize height as the maximum, 32 bpp
    configure(0, DimAllOnes, ModeBpp32, '0);
    queue_byte(8'hFF, 1'b1, 1'b1);
    queue_byte(8'hFF, 1'b0, 1'b1);
    queue_byte(8'hFF, 1'b0, 1'b1);
    queue_byte(8'h00, 1'b0, 1'b1);
    queue_byte(8'h00, 1'b0, 1'b1);
    queue_byte(8'h00, 1'b0, 1'b1);
    queue_byte(8'h00, 1'b0, 1'b1);
    queue_byte(8'hFF, 1'b0, 1'b1);

    // three bytes held, then drop to 24 bpp so the fourth lands as red
    queue_byte(8'h11, 1'b1, 1'b1);
    queue_byte(8'h22, 1'b0, 1'b1);
    queue_byte(8'h33, 1'b0, 1'b1);
    settle();
    write_reg(RegPixelSize, 32'(ModeBpp24));
    @(negedge clk);
    queue_byte(8'h44, 1'b0, 1'b1);

    // height shrinks below the current row: image ends, row wraps
    settle();
    write_reg(RegImageHeight, 1);
    @(negedge clk);
    queue_byte(8'hAB, 1'b0, 1'b1);
    queue_byte(8'h01, 1'b0, 1'b1);
    queue_byte(8'h02, 1'b0, 1'b1);
    queue_byte(8'h03, 1'b0, 1'b1);

    // long receiver hold-off while the sender keeps offering
    configure(20, 3, ModeBpp32, pick_key());
    hold_asks++;
    queue_image(400);

    while (items_sent < ItemTarget - TailItems) begin
      random_phase();
    end

    // closing part without idling on either side
    settle();
    calm_tail = 1'b1;
    send_pct = 0;
    stall_pct = 0;
    configure($urandom_range(6, 1), $urandom_range(4, 1), 1'($urandom_range(1)), pick_key());
    queue_image(TailItems / 2);
    queue_image(TailItems / 2);

    drain();
    repeat (SettleCycles) @(posedge clk);
    if (mismatches == 0 && pending_pixels.size() == 0) begin
      $display("bmp_pixel_row_unpacker regression: pass");
    end else begin
      $display("bmp_pixel_row_unpacker regression: fail");
    end
    $finish;
  end

endmodule
